/* design/ali_pkg.sv */
// Package for the ordered list block: operation and status codes,
// transaction payload structs and the broadcast control struct for the cells.
// No dependencies.
package ali_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 8;
    localparam int IDX_OUT_W = 7;
    localparam int CNT_OUT_W = 8;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } t_state;

    // Input transaction payload
    typedef struct packed {
        t_mode                    mode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } t_in;

    // Output transaction payload
    typedef struct packed {
        t_status                  status;
        logic [IDX_OUT_W-1:0]     found_index;
        logic signed [DATA_W-1:0] read_value;
        logic [CNT_OUT_W-1:0]     entry_count;
    } t_out;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic                     search;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

/* design/ali_if.sv */
// Valid/ready channel interfaces for the input and output transactions.
// Depends on ali_pkg for the payload structs.
interface ali_in_if;
    logic        valid;
    logic        ready;
    ali_pkg::t_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
    modport monitor(input valid, input data, input ready);
endinterface

interface ali_out_if;
    logic          valid;
    logic          ready;
    ali_pkg::t_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
    modport monitor(input valid, input data, input ready);
endinterface

/* design/ali_cell.sv */
// One list cell: holds one entry, shifts with its neighbors on insert and
// delete, and adds one registered stage to the first-match scan chain.
// Depends on ali_pkg.
module ali_cell #(
    parameter int LIST_DEPTH = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [$clog2(LIST_DEPTH)-1:0]        i_index,
    input  logic [$clog2(LIST_DEPTH+1)-1:0]      i_count,
    input  ali_pkg::t_cell_ctrl                  i_ctrl,
    input  logic signed [ali_pkg::DATA_W-1:0]    i_left_entry,
    input  logic signed [ali_pkg::DATA_W-1:0]    i_right_entry,
    output logic signed [ali_pkg::DATA_W-1:0]    o_entry,
    input  logic                                 i_hit,
    input  logic [$clog2(LIST_DEPTH)-1:0]        i_hit_idx,
    input  logic signed [ali_pkg::DATA_W-1:0]    i_hit_data,
    output logic                                 o_hit,
    output logic [$clog2(LIST_DEPTH)-1:0]        o_hit_idx,
    output logic signed [ali_pkg::DATA_W-1:0]    o_hit_data
);
    import ali_pkg::*;

    localparam int IW  = $clog2(LIST_DEPTH);
    localparam int CW  = $clog2(LIST_DEPTH+1);
    localparam int KPW = (CW > POS_W) ? CW : POS_W;

    logic signed [DATA_W-1:0] r_entry, n_entry;
    logic                     r_hit, n_hit;
    logic [IW-1:0]            r_hit_idx, n_hit_idx;
    logic signed [DATA_W-1:0] r_hit_data, n_hit_data;

    logic w_live, w_at_pos, w_above_pos, w_match;

    assign w_live      = CW'(i_index) < i_count;
    assign w_at_pos    = KPW'(i_index) == KPW'(i_ctrl.pos);
    assign w_above_pos = KPW'(i_index) >  KPW'(i_ctrl.pos);
    assign w_match     = w_live && (i_ctrl.search ? (r_entry == i_ctrl.value) : w_at_pos);

    // Shift: insert pulls from the left, delete pulls from the right
    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (w_above_pos) begin
                n_entry = i_left_entry;
            end else if (w_at_pos) begin
                n_entry = i_ctrl.value;
            end
        end else if (i_ctrl.del) begin
            if (w_above_pos || w_at_pos) begin
                n_entry = i_right_entry;
            end
        end
    end

    // Scan stage: keep an earlier hit, else claim this entry on a match
    always_comb begin
        if (i_hit) begin
            n_hit      = 1'b1;
            n_hit_idx  = i_hit_idx;
            n_hit_data = i_hit_data;
        end else if (w_match) begin
            n_hit      = 1'b1;
            n_hit_idx  = i_index;
            n_hit_data = r_entry;
        end else begin
            n_hit      = 1'b0;
            n_hit_idx  = '0;
            n_hit_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry    <= n_entry;
        r_hit_idx  <= n_hit_idx;
        r_hit_data <= n_hit_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_entry    = r_entry;
    assign o_hit      = r_hit;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_data = r_hit_data;

endmodule

/* design/array_list_insert_delete_search.sv */
// Channel      | Dir | Payload                                          | Handshake
// i_in_ch      | in  | mode, position, item_value                       | valid/ready
// o_out_ch     | out | status, found_index, read_value, entry_count     | valid/ready
//
// Insert and delete load the output register directly: every cell shifts in parallel.
// Search and read go through the scan state: the wait counter is loaded with
// LIST_DEPTH for the registered scan chain that runs through the cells from
// index 0 to the end, and then the output register is loaded once it is free.
// Reset (synchronous, active low) empties the list; entries stay undefined.
// A new transaction is taken when idle and the output register is free or
// being drained; a stalled result holds in the output register.
// Top level: controller plus the chain of ali_cell; uses ali_pkg and ali_if.
module array_list_insert_delete_search #(
    parameter int LIST_DEPTH = 128
) (
    input logic     i_clk,
    input logic     i_rst_n,
    ali_in_if.sink  i_in_ch,
    ali_out_if.source o_out_ch
);
    import ali_pkg::*;

    localparam int IW  = $clog2(LIST_DEPTH);
    localparam int CW  = $clog2(LIST_DEPTH+1);
    localparam int KPW = (CW > POS_W) ? CW : POS_W;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_wait, n_wait;
    t_in             r_op, n_op;
    logic            r_out_valid, n_out_valid;
    t_out            r_out, n_out;

    t_in             w_op;
    t_cell_ctrl      w_ctrl;
    logic            w_accept, w_out_free;
    logic            w_ins_ok, w_del_ok;

    logic signed [DATA_W-1:0] w_entry   [LIST_DEPTH];
    logic                     w_hit     [LIST_DEPTH+1];
    logic [IW-1:0]            w_hit_idx [LIST_DEPTH+1];
    logic signed [DATA_W-1:0] w_hit_data[LIST_DEPTH+1];

    assign w_out_free     = !r_out_valid || o_out_ch.ready;
    assign i_in_ch.ready  = (r_state == S_IDLE) && w_out_free;
    assign w_accept       = i_in_ch.valid && i_in_ch.ready;
    assign w_op           = w_accept ? i_in_ch.data : r_op;

    assign w_ins_ok = (KPW'(w_op.position) <= KPW'(r_count)) && (r_count < CW'(LIST_DEPTH));
    assign w_del_ok = KPW'(w_op.position) < KPW'(r_count);

    // Broadcast to the cells
    always_comb begin
        w_ctrl.ins    = w_accept && (i_in_ch.data.mode == MODE_INSERT) && w_ins_ok;
        w_ctrl.del    = w_accept && (i_in_ch.data.mode == MODE_DELETE) && w_del_ok;
        w_ctrl.search = w_op.mode == MODE_SEARCH;
        w_ctrl.pos    = w_op.position;
        w_ctrl.value  = w_op.item_value;
    end

    // Cell chain
    assign w_hit[0]      = 1'b0;
    assign w_hit_idx[0]  = '0;
    assign w_hit_data[0] = '0;

    for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
        logic signed [DATA_W-1:0] w_left, w_right;
        if (k == 0) begin : g_first
            assign w_left = w_entry[k];
        end else begin : g_mid_l
            assign w_left = w_entry[k-1];
        end
        if (k == LIST_DEPTH-1) begin : g_last
            assign w_right = w_entry[k];
        end else begin : g_mid_r
            assign w_right = w_entry[k+1];
        end

        ali_cell #(.LIST_DEPTH(LIST_DEPTH)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_index      (IW'(k)),
            .i_count      (r_count),
            .i_ctrl       (w_ctrl),
            .i_left_entry (w_left),
            .i_right_entry(w_right),
            .o_entry      (w_entry[k]),
            .i_hit        (w_hit[k]),
            .i_hit_idx    (w_hit_idx[k]),
            .i_hit_data   (w_hit_data[k]),
            .o_hit        (w_hit[k+1]),
            .o_hit_idx    (w_hit_idx[k+1]),
            .o_hit_data   (w_hit_data[k+1])
        );
    end

    // Controller: next state, count and output register
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_wait      = r_wait;
        n_op        = r_op;
        n_out_valid = r_out_valid && !o_out_ch.ready;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op                  = i_in_ch.data;
                    n_out.found_index     = IDX_OUT_W'(i_in_ch.data.position);
                    n_out.read_value      = '0;
                    n_out.entry_count     = CNT_OUT_W'(r_count);
                    unique case (i_in_ch.data.mode)
                        MODE_INSERT: begin
                            n_out_valid = 1'b1;
                            n_out.status = w_ins_ok ? ST_OK : ST_BAD;
                            if (w_ins_ok) begin
                                n_count           = r_count + 1'b1;
                                n_out.entry_count = CNT_OUT_W'(r_count + 1'b1);
                            end
                        end
                        MODE_DELETE: begin
                            n_out_valid = 1'b1;
                            n_out.status = w_del_ok ? ST_OK : ST_BAD;
                            if (w_del_ok) begin
                                n_count           = r_count - 1'b1;
                                n_out.entry_count = CNT_OUT_W'(r_count - 1'b1);
                            end
                        end
                        MODE_SEARCH, MODE_READ: begin
                            n_state = S_SCAN;
                            n_wait  = CW'(LIST_DEPTH);
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - 1'b1;
                end else if (w_out_free) begin
                    n_state           = S_IDLE;
                    n_out_valid       = 1'b1;
                    n_out.entry_count = CNT_OUT_W'(r_count);
                    if (r_op.mode == MODE_SEARCH) begin
                        n_out.read_value = '0;
                        if (w_hit[LIST_DEPTH]) begin
                            n_out.status      = ST_OK;
                            n_out.found_index = IDX_OUT_W'(w_hit_idx[LIST_DEPTH]);
                        end else begin
                            n_out.status      = ST_MISS;
                            n_out.found_index = '0;
                        end
                    end else begin
                        n_out.found_index = IDX_OUT_W'(r_op.position);
                        n_out.status      = w_hit[LIST_DEPTH] ? ST_OK : ST_BAD;
                        n_out.read_value  = w_hit[LIST_DEPTH] ? w_hit_data[LIST_DEPTH] : '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_out <= n_out;
    end

    assign o_out_ch.valid = r_out_valid;
    assign o_out_ch.data  = r_out;

endmodule

/* design/ali_checker.sv */
// Port-level checks for the ordered list block, bound to the top level.
// Depends on ali_pkg and ali_if.
module ali_checker #(
    parameter int LIST_DEPTH = 128
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input ali_pkg::t_out i_out_data
);
    import ali_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // No new transaction while a result is stuck in the output register
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> !i_out_valid || i_out_ready)
        else $error("input taken while output stalled");

    // Count never exceeds the list depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> 32'(i_out_data.entry_count) <= 32'(LIST_DEPTH))
        else $error("entry count above depth");

    // A miss carries zero index and zero data
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_data.status == ST_MISS) |->
            (i_out_data.found_index == '0) && (i_out_data.read_value == '0))
        else $error("miss with nonzero index or data");

endmodule

bind array_list_insert_delete_search ali_checker #(.LIST_DEPTH(LIST_DEPTH)) u_ali_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_ch.valid),
    .i_in_ready (i_in_ch.ready),
    .i_out_valid(o_out_ch.valid),
    .i_out_ready(o_out_ch.ready),
    .i_out_data (o_out_ch.data)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for array_list_insert_delete_search: directed and random list operations.
// A shadow copy of the list predicts each result, and a checker compares them field by field.
// Depends on ali_pkg, ali_if and the design top level.
module tb;
    import ali_pkg::*;

    localparam int LIST_DEPTH  = 128;
    localparam int IDLE_LIMIT  = 3000;
    localparam int RANDOM_OPS  = 1600;

    logic i_clk;
    logic i_rst_n;

    ali_in_if  in_ch();
    ali_out_if out_ch();

    array_list_insert_delete_search #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in_ch (in_ch),
        .o_out_ch(out_ch)
    );

    // Shadow list and the results it predicts
    logic signed [DATA_W-1:0] list_shadow [LIST_DEPTH];
    int                       list_len = 0;
    t_out                     pending_results[$];
    int                       error_count = 0;
    bit                       quiet_mode = 1'b0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("tb: mismatch at %0t ns: %s", $time, what);
    endtask

    // Apply one operation to the shadow list and return the result it should give
    function automatic t_out apply_list_op(input t_in op);
        t_out r;
        int   idx;
        r             = '0;
        r.status      = ST_OK;
        r.found_index = op.position[IDX_OUT_W-1:0];
        case (op.mode)
            MODE_INSERT: begin
                if (int'(op.position) > list_len || list_len >= LIST_DEPTH) begin
                    r.status = ST_BAD;
                end else begin
                    for (idx = list_len; idx > int'(op.position); idx--)
                        list_shadow[idx] = list_shadow[idx-1];
                    list_shadow[op.position[IDX_OUT_W-1:0]] = op.item_value;
                    list_len++;
                end
            end
            MODE_DELETE: begin
                if (int'(op.position) >= list_len) begin
                    r.status = ST_BAD;
                end else begin
                    for (idx = op.position; idx + 1 < list_len; idx++)
                        list_shadow[idx] = list_shadow[idx+1];
                    list_len--;
                end
            end
            MODE_SEARCH: begin
                for (idx = 0; idx < list_len; idx++)
                    if (list_shadow[idx] == op.item_value) break;
                if (idx < list_len) begin
                    r.found_index = idx[IDX_OUT_W-1:0];
                end else begin
                    r.status      = ST_MISS;
                    r.found_index = '0;
                end
            end
            default: begin
                if (int'(op.position) >= list_len)
                    r.status = ST_BAD;
                else
                    r.read_value = list_shadow[op.position[IDX_OUT_W-1:0]];
            end
        endcase
        r.entry_count = list_len[CNT_OUT_W-1:0];
        return r;
    endfunction

    // Idle length: mostly short, a few long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Drive one transaction and record its prediction once accepted
    task automatic send_list_op(input t_mode m, input logic [POS_W-1:0] p,
                                input logic signed [DATA_W-1:0] v);
        t_in op;
        int  gap;
        op  = '{mode: m, position: p, item_value: v};
        gap = (quiet_mode || $urandom_range(0, 99) < 50) ? 0 : idle_length();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= op;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        pending_results.push_back(apply_list_op(op));
    endtask

    // Hold the input side until every predicted result has arrived
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sh0;
            3: return -32'sd1;
            4, 5: return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal positions, some out of range or wide
    function automatic logic [POS_W-1:0] pick_position(input t_mode m);
        int top;
        top = (m == MODE_INSERT) ? list_len : list_len - 1;
        if (top < 0) top = 0;
        if ($urandom_range(0, 99) < 12) begin
            case ($urandom_range(0, 3))
                0: return 8'd128;
                1: return 8'd255;
                2: return (top + 1 > 255) ? 8'd255 : POS_W'(top + 1);
                default: return POS_W'($urandom_range(0, 255));
            endcase
        end
        return POS_W'($urandom_range(0, top));
    endfunction

    // One random operation, weighted toward a target fill level
    task automatic issue_random_op(input int fill_target);
        int                       r;
        t_mode                    m;
        logic [POS_W-1:0]         p;
        logic signed [DATA_W-1:0] v;
        r = $urandom_range(0, 99);
        if (list_len < fill_target)
            m = (r < 45) ? MODE_INSERT : (r < 60) ? MODE_DELETE :
                (r < 80) ? MODE_SEARCH : MODE_READ;
        else
            m = (r < 15) ? MODE_INSERT : (r < 50) ? MODE_DELETE :
                (r < 75) ? MODE_SEARCH : MODE_READ;
        p = pick_position(m);
        if (m == MODE_SEARCH && list_len > 0 && $urandom_range(0, 9) < 6)
            v = list_shadow[$urandom_range(0, list_len - 1)];
        else if (m == MODE_SEARCH || m == MODE_INSERT)
            v = pick_value();
        else
            v = $urandom;
        send_list_op(m, p, v);
    endtask

    // Empty-list cases, front/middle/end inserts, duplicates, wide positions
    task automatic test_directed();
        send_list_op(MODE_READ,   8'd0,   32'sd5);
        send_list_op(MODE_DELETE, 8'd0,   32'sd0);
        send_list_op(MODE_SEARCH, 8'd0,   32'sd0);
        send_list_op(MODE_INSERT, 8'd1,   32'sd9);
        send_list_op(MODE_INSERT, 8'd0,   32'sh7FFF_FFFF);
        send_list_op(MODE_INSERT, 8'd0,   32'sh8000_0000);
        send_list_op(MODE_INSERT, 8'd2,   -32'sd1);
        send_list_op(MODE_INSERT, 8'd1,   32'sd0);
        send_list_op(MODE_INSERT, 8'd1,   -32'sd1);
        send_list_op(MODE_SEARCH, 8'd0,   -32'sd1);
        send_list_op(MODE_SEARCH, 8'd255, 32'sd12345);
        send_list_op(MODE_READ,   8'd0,   32'sd0);
        send_list_op(MODE_READ,   8'd4,   32'sd0);
        send_list_op(MODE_READ,   8'd5,   32'sd0);
        send_list_op(MODE_READ,   8'd128, 32'sd0);
        send_list_op(MODE_READ,   8'd255, 32'sd0);
        send_list_op(MODE_DELETE, 8'd128, 32'sd0);
        send_list_op(MODE_DELETE, 8'd255, 32'sd0);
        send_list_op(MODE_INSERT, 8'd128, 32'sd7);
        send_list_op(MODE_INSERT, 8'd255, 32'sd7);
        send_list_op(MODE_DELETE, 8'd2,   32'sd0);
        send_list_op(MODE_DELETE, 8'd3,   32'sd0);
        send_list_op(MODE_DELETE, 8'd0,   32'sd0);
        send_list_op(MODE_SEARCH, 8'd0,   32'sh7FFF_FFFF);
        send_list_op(MODE_READ,   8'd1,   32'sd0);
    endtask

    // Fill to capacity, poke the full list, then drain to empty
    task automatic test_fill_and_drain();
        quiet_mode = 1'b1;
        while (list_len < LIST_DEPTH) begin
            if (list_len == LIST_DEPTH / 2) quiet_mode = 1'b0;
            send_list_op(MODE_INSERT, POS_W'($urandom_range(0, list_len)), pick_value());
        end
        wait_results_drained();
        send_list_op(MODE_INSERT, 8'd0,   32'sd1);
        send_list_op(MODE_INSERT, 8'd128, 32'sd1);
        send_list_op(MODE_READ,   8'd127, 32'sd0);
        send_list_op(MODE_READ,   8'd128, 32'sd0);
        send_list_op(MODE_SEARCH, 8'd0,   list_shadow[LIST_DEPTH-1]);
        send_list_op(MODE_DELETE, 8'd127, 32'sd0);
        while (list_len > 0)
            send_list_op(MODE_DELETE, POS_W'($urandom_range(0, list_len - 1)), $urandom);
    endtask

    // Random mix in segments with varying fill targets and idling
    task automatic test_random_mix();
        int targets[4] = '{8, 64, 124, 2};
        int seg;
        int n;
        for (seg = 0; seg < 8; seg++) begin
            quiet_mode = (seg % 3 == 1);
            for (n = 0; n < RANDOM_OPS / 8; n++)
                issue_random_op(targets[seg % 4]);
        end
        quiet_mode = 1'b0;
    endtask

    // Result checker and output-side stalls
    initial begin : result_check
        t_out expect_r;
        int   stall_left;
        stall_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with no transaction pending");
                end else begin
                    expect_r = pending_results.pop_front();
                    if (out_ch.data.status !== expect_r.status)
                        report_mismatch($sformatf("status got %0d exp %0d",
                            out_ch.data.status, expect_r.status));
                    if (out_ch.data.found_index !== expect_r.found_index)
                        report_mismatch($sformatf("found_index got %0d exp %0d",
                            out_ch.data.found_index, expect_r.found_index));
                    if (out_ch.data.read_value !== expect_r.read_value)
                        report_mismatch($sformatf("read_value got %0d exp %0d",
                            out_ch.data.read_value, expect_r.read_value));
                    if (out_ch.data.entry_count !== expect_r.entry_count)
                        report_mismatch($sformatf("entry_count got %0d exp %0d",
                            out_ch.data.entry_count, expect_r.entry_count));
                end
            end
            if (quiet_mode) begin
                stall_left   = 0;
                out_ch.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 30) begin
                stall_left   = idle_length() - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run after too many cycles without a transaction
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    // Test sequence
    initial begin
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fill_and_drain();
        test_random_mix();

        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LIST_DEPTH + 8) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
